/* rtl/running_mean_variance_defines.svh */
// Assertion macros for the running mean and variance block.
// Included by the top level; the macros assume the aclk and aresetn ports.
`ifndef RUNNING_MEAN_VARIANCE_DEFINES_SVH
`define RUNNING_MEAN_VARIANCE_DEFINES_SVH

// Condition implies consequent in the same cycle.
`define RMV_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequent in the next cycle.
`define RMV_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Condition implies consequent after a delay.
`define RMV_CHECK_AFTER2(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

/* rtl/rmv_pkg.sv */
// Shared constants and types of the running mean and variance block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rmv_pkg;

    // Port widths of the payload fields.
    localparam int IN_SAMPLE_WIDTH = 32;
    localparam int IN_COUNT_WIDTH  = 32;
    localparam int OUT_MEAN_WIDTH  = 32;
    localparam int M2_WIDTH        = 64;

    // Default working widths of sample and count.
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF  = 32;

    // The M2 add runs in digits of this width.
    localparam int ACC_DIGIT = 16;
    localparam int ACC_STEPS = M2_WIDTH / ACC_DIGIT;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_FIN
    } state_t;

    // Status of one serial unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

/* rtl/rmv_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on rmv_pkg for the status struct.
`timescale 1ns / 1ps

module rmv_divider #(
    parameter int N_WIDTH = 32,
    parameter int D_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [N_WIDTH-1:0]   dividend,
    input  logic [D_WIDTH-1:0]   divisor,
    output logic [N_WIDTH-1:0]   quotient,
    output rmv_pkg::unit_stat_t  stat
);

    localparam int CNT_W = (N_WIDTH > 1) ? $clog2(N_WIDTH) : 1;

    logic [N_WIDTH-1:0] quo_reg;
    logic [D_WIDTH-1:0] rem_reg;
    logic [D_WIDTH-1:0] dsr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [D_WIDTH:0]   rem_shift;
    logic [D_WIDTH:0]   rem_diff;
    logic               fits;
    logic               last;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[N_WIDTH-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        fits      = rem_shift >= {1'b0, dsr_reg};
        last      = cnt_reg == CNT_W'(N_WIDTH - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[N_WIDTH-2:0], fits};
            rem_reg <= fits ? rem_diff[D_WIDTH-1:0] : rem_shift[D_WIDTH-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/rmv_multiplier.sv */
// Bit-serial shift-and-add multiplier for unsigned operands.
// Depends on rmv_pkg for the status struct.
`timescale 1ns / 1ps

module rmv_multiplier #(
    parameter int WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WIDTH-1:0]     op_a,
    input  logic [WIDTH-1:0]     op_b,
    output logic [2*WIDTH-1:0]   product,
    output rmv_pkg::unit_stat_t  stat
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] hi_reg;
    logic [WIDTH-1:0] lo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [WIDTH:0]   part_sum;
    logic             last;

    always_comb begin
        part_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
        last     = cnt_reg == CNT_W'(WIDTH - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // The multiplier bits leave at the bottom while product bits enter at the top.
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= op_a;
            hi_reg <= '0;
            lo_reg <= op_b;
        end else if (busy_reg) begin
            hi_reg <= part_sum[WIDTH:1];
            lo_reg <= {part_sum[0], lo_reg[WIDTH-1:1]};
        end
    end

    assign product   = {hi_reg, lo_reg};
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/rmv_accum.sv */
// M2 accumulator: holds M2 and the saturation flag and adds an increment
// digit by digit. Depends on rmv_pkg for widths and the status struct.
`timescale 1ns / 1ps

module rmv_accum #(
    parameter int P_WIDTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic                           commit,
    input  logic [P_WIDTH-1:0]             incr,
    output logic [rmv_pkg::M2_WIDTH-1:0]   m2_result,
    output logic                           sat_result,
    output rmv_pkg::unit_stat_t            stat
);

    import rmv_pkg::*;

    localparam int CNT_W = (ACC_STEPS > 1) ? $clog2(ACC_STEPS) : 1;

    logic [M2_WIDTH-1:0] m2_reg;
    logic                sat_reg;
    logic [M2_WIDTH-1:0] a_sr_reg;
    logic [M2_WIDTH-1:0] b_sr_reg;
    logic                carry_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [ACC_DIGIT:0]  digit_sum;
    logic                last;

    always_comb begin
        digit_sum = {1'b0, a_sr_reg[ACC_DIGIT-1:0]} + {1'b0, b_sr_reg[ACC_DIGIT-1:0]}
                  + (ACC_DIGIT + 1)'(carry_reg);
        last      = cnt_reg == CNT_W'(ACC_STEPS - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            carry_reg <= 1'b0;
            m2_reg    <= '0;
            sat_reg   <= 1'b0;
        end else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                carry_reg <= 1'b0;
            end else if (busy_reg) begin
                cnt_reg   <= cnt_reg + CNT_W'(1);
                carry_reg <= digit_sum[ACC_DIGIT];
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
            if (commit) begin
                m2_reg  <= m2_result;
                sat_reg <= sat_result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_sr_reg <= m2_reg;
            b_sr_reg <= M2_WIDTH'(incr);
        end else if (busy_reg) begin
            a_sr_reg <= {digit_sum[ACC_DIGIT-1:0], a_sr_reg[M2_WIDTH-1:ACC_DIGIT]};
            b_sr_reg <= {{ACC_DIGIT{1'b0}}, b_sr_reg[M2_WIDTH-1:ACC_DIGIT]};
        end
    end

    // A carry out of the top digit means the sum overflowed: clamp and flag.
    assign m2_result  = carry_reg ? '1 : a_sr_reg;
    assign sat_result = sat_reg | carry_reg;
    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;

endmodule

/* rtl/running_mean_variance.sv */
// Running mean and variance (Welford update), top level.
// Depends on rmv_pkg, rmv_divider, rmv_multiplier, rmv_accum and the defines header.
`timescale 1ns / 1ps
`include "running_mean_variance_defines.svh"

// Each transfer on the input carries a signed fixed-point sample and its 1-based
// running count (a count of zero is taken as one). The block updates the mean by
// delta / count, truncated toward zero, adds delta * (sample - new mean) to M2 with
// saturation at its maximum, and returns one result with the new mean, M2 and the
// sticky saturation flag. Only the low SAMPLE_WIDTH bits of the sample (sign-extended)
// and the low COUNT_WIDTH bits of the count are used. Items are worked one at a time,
// each in turn through the bit-serial divider and the bit-serial multiplier, one bit
// per cycle each, and the M2 add, which runs in four 16-bit digits. A finished result
// sits in an output register, so the next sample is accepted while the previous
// result still waits for its transfer; a result is only held back from that register
// while the one before it is unread.

module running_mean_variance #(
    parameter int SAMPLE_WIDTH = rmv_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = rmv_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [rmv_pkg::IN_SAMPLE_WIDTH-1:0] s_sample_value,
    input  logic [rmv_pkg::IN_COUNT_WIDTH-1:0]    s_sample_count,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [rmv_pkg::OUT_MEAN_WIDTH-1:0]  m_running_mean,
    output logic [rmv_pkg::M2_WIDTH-1:0]          m_sum_sq_dev,
    output logic                                  m_saturated
);

    import rmv_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = COUNT_WIDTH;

    state_t state_reg;
    state_t state_next;

    // Running mean, kept at the working width.
    logic signed [SW-1:0] mean_reg;

    // Per-item working registers.
    logic [CW-1:0]        count_reg;
    logic signed [SW:0]   delta_reg;
    logic [SW-1:0]        dmag_reg;
    logic signed [SW-1:0] newmean_reg;

    // Output register.
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic signed [OUT_MEAN_WIDTH-1:0] out_mean_reg;
    logic [M2_WIDTH-1:0]         out_m2_reg;
    logic                        out_sat_reg;

    // Combinational helpers.
    logic signed [SW-1:0] sample_in;
    logic [CW-1:0]        count_in;
    logic signed [SW:0]   delta_in;
    logic signed [SW:0]   delta_abs;
    logic [SW-1:0]        dmag_in;
    logic signed [SW:0]   mean_ext;
    logic signed [SW:0]   quo_ext;
    logic signed [SW:0]   newmean_in;
    logic [SW-1:0]        resid_mag;
    logic                 accept;
    logic                 slot_free;

    // Unit control.
    logic                 div_start;
    logic                 mul_start;
    logic                 acc_start;
    logic                 commit;
    logic [SW-1:0]        quotient;
    logic [2*SW-1:0]      product;
    logic [M2_WIDTH-1:0]  m2_result;
    logic                 sat_result;
    unit_stat_t           div_stat;
    unit_stat_t           mul_stat;
    unit_stat_t           acc_stat;

    // Datapath arithmetic. The magnitude of delta always fits SW bits, and the new
    // mean always lies between the old mean and the sample, so it fits SW bits too.
    always_comb begin
        sample_in  = s_sample_value[SW-1:0];
        count_in   = s_sample_count[CW-1:0];
        delta_in   = (SW + 1)'(sample_in) - (SW + 1)'(mean_reg);
        delta_abs  = delta_reg[SW] ? -delta_reg : delta_reg;
        dmag_in    = delta_abs[SW-1:0];
        mean_ext   = (SW + 1)'(mean_reg);
        quo_ext    = signed'({1'b0, quotient});
        newmean_in = delta_reg[SW] ? (mean_ext - quo_ext) : (mean_ext + quo_ext);
        // The residual keeps the sign of delta, so only magnitudes are multiplied.
        resid_mag  = dmag_reg - quotient;
    end

    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;

    // Sequencer: next state and unit start strobes.
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        mul_start  = 1'b0;
        acc_start  = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_stat.done) begin
                    acc_start  = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (acc_stat.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // Results and state are committed together once the output is free.
                if (slot_free) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mean_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (commit) begin
                mean_reg <= newmean_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            count_reg <= (count_in == '0) ? CW'(1) : count_in;
            delta_reg <= delta_in;
        end
        if (div_start) begin
            dmag_reg <= dmag_in;
        end
        if (mul_start) begin
            newmean_reg <= newmean_in[SW-1:0];
        end
        if (commit) begin
            out_mean_reg <= OUT_MEAN_WIDTH'(newmean_reg);
            out_m2_reg   <= m2_result;
            out_sat_reg  <= sat_result;
        end
    end

    rmv_divider #(
        .N_WIDTH (SW),
        .D_WIDTH (CW)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dmag_in),
        .divisor  (count_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    rmv_multiplier #(
        .WIDTH (SW)
    ) u_multiplier (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (dmag_reg),
        .op_b    (resid_mag),
        .product (product),
        .stat    (mul_stat)
    );

    rmv_accum #(
        .P_WIDTH (2 * SW)
    ) u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (acc_start),
        .commit     (commit),
        .incr       (product),
        .m2_result  (m2_result),
        .sat_result (sat_result),
        .stat       (acc_stat)
    );

    assign s_ready        = state_reg == ST_IDLE;
    assign m_valid        = m_valid_reg;
    assign m_running_mean = out_mean_reg;
    assign m_sum_sq_dev   = out_m2_reg;
    assign m_saturated    = out_sat_reg;

    // The serial units hand over strictly in turn, never overlapping.
    `RMV_CHECK(a_one_unit_busy, 1'b1, $onehot0({div_stat.busy, mul_stat.busy, acc_stat.busy}), "more than one serial unit busy")
    // A new sample is only taken when all units are idle.
    `RMV_CHECK(a_ready_units_idle, s_ready, !div_stat.busy && !mul_stat.busy && !acc_stat.busy, "input ready while a unit is busy")
    // An accepted sample passes through the load state and then starts the divider.
    `RMV_CHECK_AFTER2(a_accept_starts_div, accept, div_stat.busy, "divider did not start after a transfer")
    // A commit always presents a result and returns to idle.
    `RMV_CHECK_NEXT(a_commit_shows_result, commit, m_valid && state_reg == ST_IDLE, "commit did not present a result")

endmodule

/* dv/tb_running_mean_variance.sv */
// Self-checking testbench for the running mean and variance block (Welford update).
// Depends on rmv_pkg and the running_mean_variance top level; reads no files.
`timescale 1ns / 1ps

module tb_running_mean_variance;

    // Idle time after the last expected result, to catch a stray extra transfer.
    localparam int DRAIN_CYCLES = 200;
    // Enough for about 1250 samples in the slowest case, several times over.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // The long output stall is far longer than several samples' worth of work,
    // so the block fills its output register and stops accepting input.
    localparam int HOLD_CYCLES  = 600;
    localparam int RANDOM_ITEMS = 1200;
    localparam int IDLE_PCT     = 34;

    // One result as the block reports it.
    typedef struct {
        logic signed [rmv_pkg::OUT_MEAN_WIDTH-1:0] mean;
        logic [rmv_pkg::M2_WIDTH-1:0]              m2;
        logic                                      sat;
    } stats_t;

    logic                                       aclk = 1'b0;
    logic                                       aresetn = 1'b0;
    logic                                       s_valid = 1'b0;
    logic                                       s_ready;
    logic signed [rmv_pkg::IN_SAMPLE_WIDTH-1:0] s_sample_value = '0;
    logic [rmv_pkg::IN_COUNT_WIDTH-1:0]         s_sample_count = '0;
    logic                                       m_valid;
    logic                                       m_ready = 1'b0;
    logic signed [rmv_pkg::OUT_MEAN_WIDTH-1:0]  m_running_mean;
    logic [rmv_pkg::M2_WIDTH-1:0]               m_sum_sq_dev;
    logic                                       m_saturated;

    // Predicted state of the block: the running mean, M2 and the sticky flag.
    // All three come out of reset at zero, exactly like the hardware.
    longint        est_mean = 0;
    logic [63:0]   est_m2 = '0;
    logic          est_sat = 1'b0;

    // Results still owed by the block, oldest first.
    stats_t        expected_stats[$];

    // Knobs and bookkeeping shared by the test tasks and the side processes.
    logic          idle_on = 1'b1;
    logic          hold_req = 1'b0;
    logic          hold_ack;
    int            hold_left;
    int            items_sent = 0;
    int            results_seen = 0;
    int            sat_results = 0;
    int            mismatches = 0;
    int            drain_pauses = 0;
    int            output_holds = 0;
    int            cycle_count = 0;

    running_mean_variance u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .s_sample_count (s_sample_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_running_mean (m_running_mean),
        .m_sum_sq_dev   (m_sum_sq_dev),
        .m_saturated    (m_saturated)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Welford step on the predicted state. The quotient delta / count truncates
    // toward zero, which is what SystemVerilog division of signed integers does.
    // The M2 increment is built from magnitudes; truncation keeps the residual at
    // the sign of delta or at zero, and a mixed sign would mean no increment.
    // The add is done one bit wider so that a carry out marks saturation.
    function automatic stats_t welford_update(input logic signed [31:0] smp,
                                              input logic [31:0] cnt);
        longint      x;
        longint      n;
        longint      delta;
        longint      new_mean;
        longint      resid;
        logic [63:0] mag_delta;
        logic [63:0] mag_resid;
        logic [63:0] incr;
        logic [64:0] total;
        stats_t      res;
        x = smp;
        n = {32'd0, cnt};
        if (n == 0)
            n = 1;
        delta    = x - est_mean;
        new_mean = est_mean + delta / n;
        resid    = x - new_mean;
        mag_delta = (delta < 0) ? -delta : delta;
        mag_resid = (resid < 0) ? -resid : resid;
        if ((delta < 0 && resid > 0) || (delta > 0 && resid < 0))
            incr = '0;
        else
            incr = mag_delta * mag_resid;
        total = {1'b0, est_m2} + {1'b0, incr};
        if (total[64]) begin
            est_m2  = '1;
            est_sat = 1'b1;
        end else begin
            est_m2 = total[63:0];
        end
        est_mean = new_mean;
        res.mean = est_mean[31:0];
        res.m2   = est_m2;
        res.sat  = est_sat;
        return res;
    endfunction

    // Offers one sample, possibly after a random gap, and returns once the
    // transfer has happened. Valid is left high on return so that a sample that
    // follows at once needs only one assignment to valid in that time step;
    // whoever pauses next lowers it.
    task automatic send_sample(input logic signed [31:0] smp, input logic [31:0] cnt);
        if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while (idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
        s_valid        <= 1'b1;
        s_sample_value <= smp;
        s_sample_count <= cnt;
        // Results come back in order, so the prediction can be queued right away.
        expected_stats.push_back(welford_update(smp, cnt));
        do
            @(posedge aclk);
        while (!s_ready);
        items_sent++;
    endtask

    // Stops offering and waits until every owed result has been transferred.
    // It always lets at least one edge pass, so valid is never lowered and
    // raised again in the same step.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (expected_stats.size() != 0);
    endtask

    // A sample of modest size, +/-64.0 in Q16.16. Keeping most of the stream
    // in this range stops M2 from saturating long before the saturation test,
    // while negative values still drive every upper bit to one.
    function automatic logic signed [31:0] small_sample();
        return $urandom_range(0, 32'h0080_0000) - 32'sh0040_0000;
    endfunction

    function automatic void log_mismatch(input string what, input logic [63:0] want,
                                         input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s mismatch: expected %h, got %h", $time, what, want, got);
    endfunction

    // The receiver. A toggle of hold_req starts a long stall that this process
    // counts itself; otherwise ready drops at random while idling is enabled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_ack  <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Checks every result transfer against the oldest prediction, field by field.
    always @(posedge aclk) begin
        stats_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_saturated)
                sat_results++;
            if (expected_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result transfer with nothing expected: mean %h m2 %h",
                             $time, m_running_mean, m_sum_sq_dev);
            end else begin
                want = expected_stats.pop_front();
                if (m_running_mean !== want.mean)
                    log_mismatch("running_mean", 64'(unsigned'(want.mean)),
                                 64'(unsigned'(m_running_mean)));
                if (m_sum_sq_dev !== want.m2)
                    log_mismatch("sum_sq_dev", want.m2, m_sum_sq_dev);
                if (m_saturated !== want.sat)
                    log_mismatch("saturated", 64'(want.sat), 64'(m_saturated));
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d results still owed", $time, expected_stats.size());
            $display("tb_running_mean_variance: errors");
            $finish;
        end
    end

    // Extremes of both fields. Zero counts and counts of one jump the mean to
    // the sample and leave M2 alone, so the full-scale samples cost nothing here.
    task automatic test_field_extremes();
        send_sample(32'sd0, 32'd0);
        send_sample(32'sh7FFF_FFFF, 32'd0);
        send_sample(32'sh8000_0000, 32'd1);
        send_sample(-32'sd1, 32'd1);
        send_sample(32'sd1, 32'h0001_0000);
        send_sample(-32'sd5, 32'hFFFF_FFFF);
        send_sample(32'sd3, 32'h8000_0000);
    endtask

    // Deltas that leave a remainder over their counts, negative and positive, so the
    // quotient has to be truncated toward zero rather than floored.
    task automatic test_rounding_toward_zero();
        send_sample(32'sd0, 32'd1);
        send_sample(-32'sd7, 32'd2);
        send_sample(32'sd7, 32'd3);
        send_sample(-32'sd9, 32'd4);
        send_sample(32'sd1, 32'd5);
    endtask

    // A short, well-formed run of Q16.16 values with counts 1, 2, 3, ...
    task automatic test_fixed_point_run();
        send_sample(32'sh0001_8000, 32'd1);
        send_sample(32'sh0002_8000, 32'd2);
        send_sample(32'sh0003_8000, 32'd3);
        send_sample(32'shFFFF_C000, 32'd4);
        send_sample(32'sh0010_0000, 32'd5);
    endtask

    // The receiver stalls for a long stretch while samples keep coming with no
    // gaps, so the output register stays full and the input has to stall too.
    // Afterwards the sender waits for the pipeline to empty before going on.
    task automatic test_output_backpressure();
        idle_on  = 1'b0;
        hold_req <= ~hold_req;
        output_holds++;
        send_sample(small_sample(), 32'd1);
        for (int k = 2; k <= 12; k++)
            send_sample(small_sample(), k);
        wait_drained();
        drain_pauses++;
        idle_on = 1'b1;
    endtask

    // Mostly well-formed runs with counts 1, 2, 3, ... and random small samples.
    // Mixed in: some runs with broken counts, samples with random full-width
    // counts, and full-scale samples that arrive with a count of zero or one.
    // A full-scale sample is followed at once by a count of one, so the mean
    // returns to the small range and M2 stays far from saturation.
    task automatic test_random_stream();
        int   sent;
        int   choice;
        int   run_len;
        int   next_pause;
        logic broken;
        sent       = 0;
        next_pause = 450;
        send_sample(small_sample(), 32'd1);
        while (sent < RANDOM_ITEMS) begin
            // A stretch in the middle of the stream runs with no idling at all.
            idle_on = (sent < 500 || sent >= 700);
            choice  = $urandom_range(0, 99);
            if (choice < 6) begin
                send_sample($urandom(), $urandom_range(0, 1));
                send_sample(small_sample(), 32'd1);
                sent += 2;
            end else if (choice < 14) begin
                send_sample(small_sample(), $urandom());
                sent++;
            end else begin
                run_len = $urandom_range(2, 16);
                broken  = ($urandom_range(0, 9) == 0);
                for (int k = 1; k <= run_len; k++) begin
                    if (broken && $urandom_range(0, 3) == 0)
                        send_sample(small_sample(), $urandom_range(0, 3 * k));
                    else
                        send_sample(small_sample(), k);
                end
                sent += run_len;
            end
            if (sent >= next_pause) begin
                wait_drained();
                drain_pauses++;
                next_pause += 450;
            end
        end
        idle_on = 1'b1;
    endtask

    // Swinging between the two full-scale extremes with a count of two adds
    // close to 2^63 to M2 each time, so M2 must pin at its maximum and raise
    // the flag. The swings also take the mean to the edges of its range. The
    // flag is sticky until reset, which is why this test runs last.
    task automatic test_m2_saturation();
        for (int k = 0; k < 3; k++) begin
            send_sample(32'sh7FFF_FFFF, 32'd1);
            send_sample(32'sh8000_0000, 32'd2);
        end
        send_sample(32'sh8000_0000, 32'd1);
        send_sample(32'sh7FFF_FFFF, 32'd2);
        send_sample(32'sd0, 32'd0);
        send_sample(32'sh0001_0000, 32'hFFFF_FFFF);
        send_sample(-32'sd3, 32'd2);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_rounding_toward_zero();
        test_fixed_point_run();
        test_output_backpressure();
        test_random_stream();
        test_m2_saturation();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d samples and checked %0d results, %0d of them with M2 saturated.",
                 items_sent, results_seen, sat_results);
        $display("Output held off %0d time(s), sender drained %0d time(s), %0d mismatch(es).",
                 output_holds, drain_pauses, mismatches);
        if (mismatches == 0)
            $display("tb_running_mean_variance: clean");
        else
            $display("tb_running_mean_variance: errors");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/rmv_pkg.sv
rtl/rmv_divider.sv
rtl/rmv_multiplier.sv
rtl/rmv_accum.sv
rtl/running_mean_variance.sv
dv/tb_running_mean_variance.sv
